/* hw/rtl/block_shannon_entropy_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the block entropy unit
// Clocked concurrent assertion helpers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef BLOCK_SHANNON_ENTROPY_UNIT_DEFINES_SVH
`define BLOCK_SHANNON_ENTROPY_UNIT_DEFINES_SVH

// Generic clocked property with reset disable.
`define SBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A stalled output item keeps the given signal unchanged.
`define SBE_HOLD(lbl, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (m_axis_tvalid && !m_axis_tready) |=> $stable(sig)) else $error(msg);

`endif

/* hw/rtl/sbe_pkg.sv */
// ----------------------------------------------------------------------------
// sbe_pkg
// Shared types and constants of the block entropy unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package sbe_pkg;

  localparam int LOG_FRAC = 20;
  localparam int BINS     = 256;
  localparam int BIN_W    = 8;
  localparam logic [31:0] H_MAX20 = 32'(8) << LOG_FRAC;

  // Configuration register indexes.
  localparam logic CFG_BLOCK_SIZE  = 1'b0;
  localparam logic CFG_CHART_WIDTH = 1'b1;

  // Operand choice for the shared log unit.
  typedef enum logic [1:0] {
    LSEL_INC,
    LSEL_CUR,
    LSEL_N
  } log_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     accept;
    logic     upd_hist;
    logic     log_start;
    log_sel_e log_sel;
    logic     mul;
    logic     add;
    logic     sub;
    logic     div_start;
    logic     res;
    logic     bar;
    logic     load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic log_busy;
    logic div_busy;
    logic close;
    logic out_full;
  } sts_t;

endpackage
`default_nettype wire

/* hw/rtl/block_shannon_entropy_unit.sv */
// Each item, closing or not, runs two log2 operations in turn; the second one does no
// iterations when its bin is still empty, so that run is in effect skipped.
// A closing item then runs log2(n), the 38-step divider at the default MAX_BLOCK and
// the entropy, bar and output load, plus any wait for the output register. Only one
// item is in work at a time, with no overlap.
// Reset is asynchronous and active low; the histogram clears by valid bits.
// ----------------------------------------------------------------------------
// block_shannon_entropy_unit
// Per-block byte histogram with Shannon entropy and chart bar output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module block_shannon_entropy_unit
  import sbe_pkg::*;
#(
  parameter int MAX_BLOCK = 4096
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // byte_value[7:0]
  input  wire logic         s_axis_tlast,   // end_of_file
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // block_number[31:0], block_offset[63:32], block_bytes[76:64],
  // entropy_value[96:77], bar_length[103:97]
  output logic [103:0]      m_axis_tdata,
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_idx_i,
  input  wire logic [12:0]  cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  sbe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sbe_datapath #(.MAX_BLOCK(MAX_BLOCK)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .byte_i      (s_axis_tdata),
    .eof_i       (s_axis_tlast),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  assign m_axis_tvalid = sts.out_full;

endmodule
`default_nettype wire

/* hw/rtl/sbe_ram.sv */
// ----------------------------------------------------------------------------
// sbe_ram
// Simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/sbe_log2.sv */
// ----------------------------------------------------------------------------
// sbe_log2
// Iterative fixed-point log2, one squaring step of the mantissa per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sbe_log2
  import sbe_pkg::*;
#(
  parameter int XW = 13
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [XW-1:0]                    x_i,
  output logic                                  busy_o,
  output logic [$clog2(XW)+LOG_FRAC-1:0]        res_o
);

  localparam int LW = $clog2(XW) + LOG_FRAC;

  logic [4:0]    kk;
  logic [31:0]   m0;
  logic [63:0]   sq;
  logic [32:0]   t;
  logic [31:0]   m_q;
  logic [LW-1:0] res_q;
  logic [4:0]    cnt_q;
  logic          busy_q;

  // Leading one position and normalized mantissa.
  always_comb begin
    kk = '0;
    for (int i = 0; i < XW; i++) begin
      if (x_i[i]) begin
        kk = 5'(i);
      end
    end
    m0 = 32'(x_i) << (5'd31 - kk);
    sq = 64'(m_q) * 64'(m_q);
    t  = 33'(sq >> 31);
  end

  // Squaring iterations, most significant fraction bit first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      m_q    <= '0;
      res_q  <= '0;
    end else if (start_i) begin
      m_q   <= m0;
      cnt_q <= 5'(LOG_FRAC - 1);
      if (x_i == '0) begin
        res_q  <= '0;
        busy_q <= 1'b0;
      end else begin
        res_q  <= LW'(kk) << LOG_FRAC;
        busy_q <= 1'b1;
      end
    end else if (busy_q) begin
      if (t[32]) begin
        m_q   <= t[32:1];
        res_q <= res_q | (LW'(1) << cnt_q);
      end else begin
        m_q <= t[31:0];
      end
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 5'd1;
      end
    end
  end

  assign busy_o = busy_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

/* hw/rtl/sbe_datapath.sv */
// ----------------------------------------------------------------------------
// sbe_datapath
// Histogram memory, weighted log sum, divider and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sbe_datapath
  import sbe_pkg::*;
#(
  parameter int MAX_BLOCK = 4096
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire cmd_t         cmd_i,
  output sts_t              sts_o,
  input  wire logic [7:0]   byte_i,
  input  wire logic         eof_i,
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_idx_i,
  input  wire logic [12:0]  cfg_data_i,
  input  wire logic         out_ready_i,
  output logic [103:0]      out_data_o
);

  localparam int CW  = $clog2(MAX_BLOCK + 1);
  localparam int LW  = $clog2(CW) + LOG_FRAC;
  localparam int SW  = CW + LW + 1;
  localparam int DCW = $clog2(SW + 1);

  logic [12:0]       bsize_q;
  logic [6:0]        cwidth_q;
  logic [BIN_W-1:0]  byte_q;
  logic              eof_q;
  logic [BINS-1:0]   vld_q;
  logic [CW-1:0]     rdata;
  logic [CW-1:0]     c_q;
  logic [CW-1:0]     c_rd;
  logic [CW-1:0]     n_q;
  logic [31:0]       off_q;
  logic [31:0]       blk_q;
  logic [SW-1:0]     sum_q;
  logic [SW-1:0]     prod_q;
  logic [CW-1:0]     log_x;
  logic [LW-1:0]     log_res;
  logic              log_busy;
  logic [CW:0]       rem_q;
  logic [SW-1:0]     quo_q;
  logic [DCW-1:0]    dcnt_q;
  logic              div_busy_q;
  logic [CW:0]       rem_sh;
  logic [16:0]       limit;
  logic [31:0]       h20;
  logic [19:0]       h16_q;
  logic [26:0]       bar_prod_q;
  logic [7:0]        bar_raw;
  logic [6:0]        bar;
  logic              out_full_q;
  logic [103:0]      out_q;

  // Histogram bins.
  sbe_ram #(.WIDTH(CW), .DEPTH(BINS)) u_hist (
    .clk_i   (clk_i),
    .we_i    (cmd_i.upd_hist),
    .waddr_i (byte_q),
    .wdata_i (c_rd + CW'(1)),
    .re_i    (cmd_i.accept),
    .raddr_i (byte_i),
    .rdata_o (rdata)
  );

  // A bin not touched in this block reads as zero.
  assign c_rd = vld_q[byte_q] ? rdata : '0;

  // Log operand selection.
  always_comb begin
    case (cmd_i.log_sel)
      LSEL_INC: log_x = c_q + CW'(1);
      LSEL_CUR: log_x = c_q;
      default:  log_x = n_q;
    endcase
  end

  sbe_log2 #(.XW(CW)) u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.log_start),
    .x_i     (log_x),
    .busy_o  (log_busy),
    .res_o   (log_res)
  );

  // Effective block size.
  always_comb begin
    if (bsize_q == '0) begin
      limit = 17'd1;
    end else if (17'(bsize_q) > 17'(MAX_BLOCK)) begin
      limit = 17'(MAX_BLOCK);
    end else begin
      limit = 17'(bsize_q);
    end
  end

  // Entropy and bar arithmetic.
  always_comb begin
    rem_sh = {rem_q[CW-1:0], quo_q[SW-1]};
    if (quo_q >= SW'(log_res)) begin
      h20 = '0;
    end else begin
      h20 = 32'(SW'(log_res) - quo_q);
    end
    if (h20 > H_MAX20) begin
      h20 = H_MAX20;
    end
    bar_raw = 8'(bar_prod_q >> 19);
    bar     = (bar_raw > 8'(cwidth_q)) ? cwidth_q : bar_raw[6:0];
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsize_q  <= 13'd4096;
      cwidth_q <= 7'd40;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BLOCK_SIZE:  bsize_q  <= cfg_data_i;
        CFG_CHART_WIDTH: cwidth_q <= cfg_data_i[6:0];
        default:         ;
      endcase
    end
  end

  // Control state: block counters, valid bits, sum, divider, output flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      n_q        <= '0;
      off_q      <= '0;
      blk_q      <= '0;
      sum_q      <= '0;
      div_busy_q <= 1'b0;
      dcnt_q     <= '0;
      out_full_q <= 1'b0;
    end else begin
      if (cmd_i.upd_hist) begin
        vld_q[byte_q] <= 1'b1;
        n_q           <= n_q + CW'(1);
      end
      if (cmd_i.add) begin
        sum_q <= sum_q + prod_q;
      end
      if (cmd_i.sub) begin
        sum_q <= sum_q - prod_q;
      end
      if (cmd_i.div_start) begin
        div_busy_q <= 1'b1;
        dcnt_q     <= DCW'(SW - 1);
      end else if (div_busy_q) begin
        if (dcnt_q == '0) begin
          div_busy_q <= 1'b0;
        end else begin
          dcnt_q <= dcnt_q - DCW'(1);
        end
      end
      if (out_full_q && out_ready_i) begin
        out_full_q <= 1'b0;
      end
      if (cmd_i.load_out) begin
        out_full_q <= 1'b1;
        vld_q      <= '0;
        n_q        <= '0;
        sum_q      <= '0;
        off_q      <= off_q + 32'(n_q);
        blk_q      <= blk_q + 32'd1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= byte_i;
      eof_q  <= eof_i;
    end
    if (cmd_i.upd_hist) begin
      c_q <= c_rd;
    end
    if (cmd_i.mul) begin
      prod_q <= SW'((cmd_i.log_sel == LSEL_INC) ? (c_q + CW'(1)) : c_q) * SW'(log_res);
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= sum_q;
    end else if (div_busy_q) begin
      if (rem_sh >= (CW+1)'(n_q)) begin
        rem_q <= rem_sh - (CW+1)'(n_q);
        quo_q <= {quo_q[SW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[SW-2:0], 1'b0};
      end
    end
    if (cmd_i.res) begin
      h16_q <= 20'(h20 >> 4);
    end
    if (cmd_i.bar) begin
      bar_prod_q <= 27'(h16_q) * 27'(cwidth_q);
    end
    if (cmd_i.load_out) begin
      out_q <= {bar, h16_q, 13'(n_q), off_q, blk_q};
    end
  end

  assign sts_o.log_busy = log_busy;
  assign sts_o.div_busy = div_busy_q;
  assign sts_o.close    = eof_q || (17'(n_q) >= limit);
  assign sts_o.out_full = out_full_q;
  assign out_data_o     = out_q;

endmodule
`default_nettype wire

/* hw/rtl/sbe_ctrl.sv */
// ----------------------------------------------------------------------------
// sbe_ctrl
// Sequencer for the per-item histogram update and the block close.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sbe_ctrl
  import sbe_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_L1, ST_W1, ST_A1, ST_L2, ST_W2, ST_S2,
    ST_LN, ST_WN, ST_DIV, ST_RES, ST_BAR, ST_OUT
  } state_e;

  state_e state_q, state_d;

  // Command decode and next state.
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    cmd_o.log_sel = LSEL_INC;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i) state_d = ST_READ;
      end
      ST_READ: begin
        cmd_o.upd_hist = 1'b1;
        state_d = ST_L1;
      end
      ST_L1: begin
        cmd_o.log_start = 1'b1;
        state_d = ST_W1;
      end
      ST_W1: begin
        if (!sts_i.log_busy) begin
          cmd_o.mul = 1'b1;
          state_d = ST_A1;
        end
      end
      ST_A1: begin
        cmd_o.add = 1'b1;
        state_d = ST_L2;
      end
      ST_L2: begin
        cmd_o.log_sel   = LSEL_CUR;
        cmd_o.log_start = 1'b1;
        state_d = ST_W2;
      end
      ST_W2: begin
        cmd_o.log_sel = LSEL_CUR;
        if (!sts_i.log_busy) begin
          cmd_o.mul = 1'b1;
          state_d = ST_S2;
        end
      end
      ST_S2: begin
        cmd_o.sub = 1'b1;
        state_d = sts_i.close ? ST_LN : ST_IDLE;
      end
      ST_LN: begin
        cmd_o.log_sel   = LSEL_N;
        cmd_o.log_start = 1'b1;
        state_d = ST_WN;
      end
      ST_WN: begin
        if (!sts_i.log_busy) begin
          cmd_o.div_start = 1'b1;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!sts_i.div_busy) state_d = ST_RES;
      end
      ST_RES: begin
        cmd_o.res = 1'b1;
        state_d = ST_BAR;
      end
      ST_BAR: begin
        cmd_o.bar = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!sts_i.out_full) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule
`default_nettype wire

/* hw/rtl/sbe_checker.sv */
// ----------------------------------------------------------------------------
// sbe_checker
// Port-level checks of the block entropy unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "block_shannon_entropy_unit_defines.svh"
module sbe_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [103:0] m_axis_tdata
);

  // A stalled result stays offered with the same payload.
  `SBE_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "result dropped")
  `SBE_HOLD(a_out_stable, m_axis_tdata, "stalled result changed")

  // Entropy never exceeds eight bits per byte.
  `SBE_ASSERT(a_h_range, m_axis_tvalid |-> (m_axis_tdata[96:77] <= 20'd524288), "entropy range")

  // The unit works on one item at a time.
  `SBE_ASSERT(a_one_item, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "item overlap")

endmodule

bind block_shannon_entropy_unit sbe_checker u_sbe_checker (.*);
`default_nettype wire

/* verif/block_shannon_entropy_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block entropy checker
// Watches the byte and result streams and the register port, predicts each
// closed block's index, offset, size, entropy and bar, and compares.
// ----------------------------------------------------------------------------
module block_shannon_entropy_checker
  import sbe_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,
  input  wire logic         s_axis_tlast,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [103:0] m_axis_tdata,
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_idx_i,
  input  wire logic [12:0]  cfg_data_i,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    logic [6:0]  bar;
    logic [19:0] entropy;
    logic [12:0] nbytes;
    logic [31:0] offset;
    logic [31:0] number;
  } block_res_t;

  block_res_t  block_q[$];
  int unsigned hist[256];
  int unsigned fill;
  logic [31:0] offs;
  logic [31:0] blk;
  logic [63:0] wsum;
  logic [12:0] size_reg;
  logic [6:0]  width_reg;

  // Log2 in units of 2^-20 by repeated squaring of the mantissa.
  function automatic logic [63:0] log2_fx(input int unsigned x);
    int unsigned k;
    logic [63:0] m;
    logic [63:0] r;
    k = 0;
    if (x == 0) return 64'd0;
    while (k < 31 && (x >> (k + 1)) != 0) k++;
    m = 64'(x) << (31 - k);
    r = 64'(k) << LOG_FRAC;
    for (int i = LOG_FRAC - 1; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  // Count one byte; queue the block result when the block closes.
  task automatic count_byte(input logic [7:0] b, input logic eof);
    int unsigned lim;
    int unsigned c;
    logic [63:0] h;
    logic [63:0] sub;
    logic [63:0] bar;
    block_res_t r;
    lim = size_reg;
    if (lim == 0) lim = 1;
    if (lim > 4096) lim = 4096;
    c = hist[b];
    wsum = wsum + 64'(c + 1) * log2_fx(c + 1) - 64'(c) * log2_fx(c);
    hist[b] = c + 1;
    fill++;
    if (!eof && fill < lim) return;
    h = log2_fx(fill);
    sub = wsum / fill;
    h = (sub >= h) ? 64'd0 : h - sub;
    if (h > 64'(H_MAX20)) h = 64'(H_MAX20);
    h = h >> 4;
    bar = (h * width_reg) >> 19;
    if (bar > width_reg) bar = width_reg;
    r.number = blk;
    r.offset = offs;
    r.nbytes = fill[12:0];
    r.entropy = h[19:0];
    r.bar = bar[6:0];
    block_q = {block_q, r};
    blk++;
    offs = offs + fill;
    foreach (hist[i]) hist[i] = 0;
    fill = 0;
    wsum = 0;
  endtask

  // Sample all channels at the clock edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (hist[i]) hist[i] = 0;
      fill = 0;
      offs = 0;
      blk = 0;
      wsum = 0;
      size_reg = 13'd4096;
      width_reg = 7'd40;
      fail_count_o = 0;
      block_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_BLOCK_SIZE) size_reg = cfg_data_i;
        else width_reg = cfg_data_i[6:0];
      end
      if (s_axis_tvalid && s_axis_tready) count_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        block_res_t got;
        block_res_t exp_r;
        got = m_axis_tdata;
        if (block_q.size() == 0) begin
          $error("unexpected result item %h", m_axis_tdata);
          fail_count_o++;
        end else begin
          exp_r = block_q.pop_front();
          if (got.number !== exp_r.number) begin
            $error("block_number exp %0d got %0d", exp_r.number, got.number);
            fail_count_o++;
          end
          if (got.offset !== exp_r.offset) begin
            $error("block_offset exp %0d got %0d", exp_r.offset, got.offset);
            fail_count_o++;
          end
          if (got.nbytes !== exp_r.nbytes) begin
            $error("block_bytes exp %0d got %0d", exp_r.nbytes, got.nbytes);
            fail_count_o++;
          end
          if (got.entropy !== exp_r.entropy) begin
            $error("entropy_value exp %0d got %0d", exp_r.entropy, got.entropy);
            fail_count_o++;
          end
          if (got.bar !== exp_r.bar) begin
            $error("bar_length exp %0d got %0d", exp_r.bar, got.bar);
            fail_count_o++;
          end
        end
      end
      pending_o = block_q.size();
    end
  end

endmodule

/* verif/tb_block_shannon_entropy_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block entropy unit testbench
// Drives byte files under several block sizes and chart widths with random
// gaps and output stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_block_shannon_entropy_unit;
  import sbe_pkg::*;

  localparam int WATCHDOG = 200000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;   // byte_value[7:0]
  logic         s_axis_tlast;   // end_of_file
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // block_number, block_offset, block_bytes, entropy_value, bar_length
  logic [103:0] m_axis_tdata;
  logic         cfg_we_i;
  logic         cfg_idx_i;
  logic [12:0]  cfg_data_i;
  int           fail_count;
  int           pending;
  int           idle_cycles;
  bit           long_hold;

  block_shannon_entropy_unit dut (.*);
  block_shannon_entropy_checker chk (.*, .fail_count_o(fail_count), .pending_o(pending));

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Send one byte with a random gap before it. The valid stays high after
  // the accept so that a back-to-back item needs no second update.
  task automatic send_byte(input logic [7:0] b, input logic eof);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eof;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop offering, wait for every result, then let the last byte settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  // One register write; the write enable then drops before the task returns.
  task automatic write_reg(input logic idx, input logic [12:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random file bytes drawn from a small or full alphabet.
  task automatic send_file(input int len);
    int alpha;
    alpha = $urandom_range(0, 2) == 0 ? 1 : ($urandom_range(0, 1) ? 256 : 4);
    for (int i = 0; i < len; i++)
      send_byte(alpha == 256 ? 8'($urandom) : 8'($urandom_range(0, alpha - 1)),
                i == len - 1);
  endtask

  // Receiver: random stalls plus one long hold-off.
  initial begin
    int w;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end
      w = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) w = 0;
      if (w != 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    idle_cycles = 0;
    long_hold = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'd0;
    s_axis_tlast = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_BLOCK_SIZE;
    cfg_data_i = 13'd0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: default sizes, byte extremes, single-byte file.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h7F, 1'b1);
    drain();
    // Size 0 acts as 1, width 120.
    write_reg(CFG_BLOCK_SIZE, 13'd0);
    write_reg(CFG_CHART_WIDTH, 13'd120);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    drain();
    // Uniform 256 bytes gives entropy 8; width 0 and then 127.
    write_reg(CFG_BLOCK_SIZE, 13'd256);
    write_reg(CFG_CHART_WIDTH, 13'd0);
    for (int i = 0; i < 256; i++) send_byte(8'(i), 1'b0);
    drain();
    write_reg(CFG_CHART_WIDTH, 13'd127);
    for (int i = 0; i < 256; i++) send_byte(8'(255 - i), 1'b0);
    drain();
    // Size above the maximum, then lowered mid-block.
    write_reg(CFG_BLOCK_SIZE, 13'h1FFF);
    write_reg(CFG_CHART_WIDTH, 13'd1);
    for (int i = 0; i < 10; i++) send_byte(8'($urandom), 1'b0);
    drain();
    write_reg(CFG_BLOCK_SIZE, 13'd4);
    send_byte(8'h01, 1'b0);
    drain();
    // Single-byte files at size 4096, then a long receiver hold.
    write_reg(CFG_BLOCK_SIZE, 13'd4096);
    write_reg(CFG_CHART_WIDTH, 13'd40);
    for (int i = 0; i < 100; i++) send_byte(8'($urandom_range(0, 3)), 1'b1);
    long_hold = 1'b1;
    for (int i = 0; i < 30; i++) send_byte(8'($urandom), 1'b1);
    drain();

    // Random phases of files under various settings.
    for (int p = 0; p < 7; p++) begin
      write_reg(CFG_BLOCK_SIZE, 13'($urandom_range(1, 40)));
      write_reg(CFG_CHART_WIDTH, 13'($urandom_range(1, 120)));
      for (int f = 0; f < 6; f++) send_file($urandom_range(1, 40));
      for (int i = 0; i < 4; i++) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/sbe_pkg.sv
hw/rtl/sbe_ram.sv
hw/rtl/sbe_log2.sv
hw/rtl/sbe_datapath.sv
hw/rtl/sbe_ctrl.sv
hw/rtl/block_shannon_entropy_unit.sv
hw/rtl/sbe_checker.sv
verif/block_shannon_entropy_checker.sv
verif/tb_block_shannon_entropy_unit.sv
